>>> rtl/rch_pkg.sv
package rch_pkg;

  localparam int MAX_REGION_DEF = 4096;
  localparam int HIST_BINS_DEF  = 256;
  localparam int DEPTH_BITS_DEF = 16;

  localparam int POS_W  = 31;
  localparam int SPAN_W = 16;
  localparam int SEL_W  = 8;
  localparam int OUT_W  = 13;
  localparam int CFG_AW = 1;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam logic [CFG_AW-1:0] CFG_FIRST_BASE = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_LAST_BASE  = 1'd1;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_BIN = 1'b1;

  typedef struct packed {
    logic              action;
    logic [POS_W-1:0]  read_start;
    logic [SPAN_W-1:0] read_span;
    logic [SEL_W-1:0]  bin_select;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] finalized_front;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC_A,
    S_CALC_B,
    S_CALC_C,
    S_INC,
    S_FLUSH,
    S_DRAIN,
    S_HREAD,
    S_OUT
  } state_t;

endpackage

>>> rtl/rch_ram.sv
module rch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the entry written in the same cycle returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/region_coverage_histogram.sv
// Region read-depth coverage histogram.
// Input channel (in_valid/in_stall/in_data): one item per transfer. An add
// item carries a read start and span; if the read's start or end lies in the
// region, every base of the read, clipped to the region, gets its depth
// counter incremented, and the bases between the finalized front and the
// clipped read start are flushed into the depth histogram. A bin item reads one histogram bin back.
// Output channel (out_valid/out_stall/out_data): exactly one result per item,
// with the bin count (0 for add items) and the finalized front.
// Config port (cfg_we/cfg_addr/cfg_data): region first and last base; write
// only while no item is in flight.
// An add item visits the depth memory one entry per cycle, covered bases
// first and then flushed bases. One item is worked on at a time; the next
// one is taken while a finished result waits in the output register.
// Reset: a clearing pass over every address zeroes both memories; in_stall
// is high until it is done.
// A stalled output holds its result; the block finishes the current item
// and then waits with in_stall high until the result is taken.
module region_coverage_histogram #(
  parameter int MAX_REGION = rch_pkg::MAX_REGION_DEF,
  parameter int HIST_BINS  = rch_pkg::HIST_BINS_DEF,
  parameter int DEPTH_BITS = rch_pkg::DEPTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rch_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rch_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [rch_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [rch_pkg::POS_W-1:0]    cfg_data
);

  localparam int DM_AW = $clog2(MAX_REGION);
  localparam int HB_AW = $clog2(HIST_BINS);
  localparam int LEN_W = $clog2(MAX_REGION + 1);
  localparam int HC_W  = $clog2(MAX_REGION + 1);
  localparam int CLR_N = (MAX_REGION > HIST_BINS) ? MAX_REGION : HIST_BINS;
  localparam int CLR_W = $clog2(CLR_N);
  localparam int POS_W = rch_pkg::POS_W;
  localparam int OUT_W = rch_pkg::OUT_W;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  rch_pkg::state_t state_r, state_nxt;

  logic [POS_W-1:0]  first_r, last_r;
  rch_pkg::in_item_t item_r, item_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [POS_W:0]    stop_r, stop_nxt;
  logic [POS_W:0]    rend_r, rend_nxt;
  logic [DM_AW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [DM_AW-1:0]  front_r, front_nxt;
  logic [DM_AW-1:0]  idx_r, idx_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;

  // depth increment pipe and flush pipe
  logic              inc_v_r, inc_v_nxt;
  logic [DM_AW-1:0]  inc_addr_r, inc_addr_nxt;
  logic              fl_v1_r, fl_v1_nxt;
  logic              fl_v2_r;
  logic [HB_AW-1:0]  fl_bin_r, fl_bin;
  logic              fwd_v_r;
  logic [HB_AW-1:0]  fwd_bin_r;
  logic [HC_W-1:0]   fwd_val_r;

  logic                out_valid_r, out_valid_nxt;
  rch_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                  dm_we, dm_re;
  logic [DM_AW-1:0]      dm_waddr, dm_raddr;
  logic [DEPTH_BITS-1:0] dm_wdata, dm_rdata;
  logic                  hb_we, hb_re;
  logic [HB_AW-1:0]      hb_waddr, hb_raddr;
  logic [HC_W-1:0]       hb_wdata, hb_rdata, hb_old;

  logic              sel_ok;
  logic [POS_W-1:0]  diff;
  logic              in_s, in_e, use_aln;
  logic [POS_W:0]    first_x, start_x;

  rch_ram #(.WIDTH(DEPTH_BITS), .DEPTH(MAX_REGION)) u_depth_ram (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  rch_ram #(.WIDTH(HC_W), .DEPTH(HIST_BINS)) u_hist_ram (
    .clk   (clk),
    .we    (hb_we),
    .waddr (hb_waddr),
    .wdata (hb_wdata),
    .re    (hb_re),
    .raddr (hb_raddr),
    .rdata (hb_rdata)
  );

  assign first_x = {1'b0, first_r};
  assign start_x = {1'b0, item_r.read_start};
  assign sel_ok  = 32'(item_r.bin_select) < 32'(HIST_BINS);
  assign diff    = last_r - first_r;

  assign fl_bin = (32'(dm_rdata) >= 32'(HIST_BINS - 1)) ? HB_AW'(HIST_BINS - 1)
                                                       : HB_AW'(dm_rdata);
  assign hb_old = (fwd_v_r && fwd_bin_r == fl_bin_r) ? fwd_val_r : hb_rdata;

  assign in_s = (item_r.read_start >= first_r) && (start_x < rend_r);
  assign in_e = (stop_r >= first_x) && (stop_r < rend_r);
  assign use_aln = (len_r != '0) && (in_s || in_e);

  assign in_stall  = (state_r != rch_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    len_nxt       = len_r;
    stop_nxt      = stop_r;
    rend_nxt      = rend_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    front_nxt     = front_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    inc_v_nxt     = 1'b0;
    inc_addr_nxt  = idx_r;
    fl_v1_nxt     = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    dm_re    = 1'b0;
    dm_raddr = idx_r;
    dm_we    = inc_v_r;
    dm_waddr = inc_addr_r;
    dm_wdata = (dm_rdata == DEPTH_MAX) ? dm_rdata : dm_rdata + DEPTH_BITS'(1);
    hb_re    = fl_v1_r;
    hb_raddr = fl_bin;
    hb_we    = fl_v2_r;
    hb_waddr = fl_bin_r;
    hb_wdata = hb_old + HC_W'(1);

    unique case (state_r)
      rch_pkg::S_CLEAR: begin
        dm_we    = 32'(clr_r) < 32'(MAX_REGION);
        dm_waddr = DM_AW'(clr_r);
        dm_wdata = '0;
        hb_we    = 32'(clr_r) < 32'(HIST_BINS);
        hb_waddr = HB_AW'(clr_r);
        hb_wdata = '0;
        clr_nxt  = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = rch_pkg::S_IDLE;
        end
      end
      rch_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = (in_data.action == rch_pkg::ACT_BIN) ? rch_pkg::S_HREAD
                                                           : rch_pkg::S_CALC_A;
        end
      end
      rch_pkg::S_CALC_A: begin
        if (last_r < first_r) begin
          len_nxt = '0;
        end else if (32'(diff) >= 32'(MAX_REGION - 1)) begin
          len_nxt = LEN_W'(MAX_REGION);
        end else begin
          len_nxt = LEN_W'(diff) + LEN_W'(1);
        end
        stop_nxt  = start_x + (POS_W + 1)'(item_r.read_span);
        state_nxt = rch_pkg::S_CALC_B;
      end
      rch_pkg::S_CALC_B: begin
        rend_nxt  = first_x + (POS_W + 1)'(len_r);
        state_nxt = rch_pkg::S_CALC_C;
      end
      rch_pkg::S_CALC_C: begin
        lo_nxt = (item_r.read_start > first_r) ? DM_AW'(item_r.read_start - first_r)
                                               : '0;
        hi_nxt = (stop_r >= rend_r) ? DM_AW'(len_r - LEN_W'(1))
                                    : DM_AW'(stop_r - first_x);
        idx_nxt   = lo_nxt;
        state_nxt = use_aln ? rch_pkg::S_INC : rch_pkg::S_OUT;
      end
      rch_pkg::S_INC: begin
        dm_re     = 1'b1;
        inc_v_nxt = 1'b1;
        if (idx_r == hi_r) begin
          if (lo_r > front_r) begin
            idx_nxt   = front_r;
            front_nxt = lo_r;
            state_nxt = rch_pkg::S_FLUSH;
          end else begin
            state_nxt = rch_pkg::S_DRAIN;
          end
        end else begin
          idx_nxt = idx_r + DM_AW'(1);
        end
      end
      rch_pkg::S_FLUSH: begin
        // range [front, lo) is disjoint from [lo, hi], so no hazard with the
        // increments still in flight
        dm_re     = 1'b1;
        fl_v1_nxt = 1'b1;
        idx_nxt   = idx_r + DM_AW'(1);
        if (idx_nxt == lo_r) begin
          state_nxt = rch_pkg::S_DRAIN;
        end
      end
      rch_pkg::S_DRAIN: begin
        if (!inc_v_r && !fl_v1_r && !fl_v2_r) begin
          state_nxt = rch_pkg::S_OUT;
        end
      end
      rch_pkg::S_HREAD: begin
        hb_re     = sel_ok;
        hb_raddr  = HB_AW'(item_r.bin_select);
        state_nxt = rch_pkg::S_OUT;
      end
      rch_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.finalized_front = OUT_W'(front_r);
          if (item_r.action == rch_pkg::ACT_BIN && sel_ok) begin
            out_data_nxt.bin_count = (32'(hb_rdata) > 32'(rch_pkg::OUT_MAX))
                                     ? rch_pkg::OUT_MAX : OUT_W'(hb_rdata);
          end else begin
            out_data_nxt.bin_count = '0;
          end
          state_nxt = rch_pkg::S_IDLE;
        end
      end
      default: state_nxt = rch_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rch_pkg::S_CLEAR;
      clr_r       <= '0;
      front_r     <= '0;
      first_r     <= '0;
      last_r      <= POS_W'(4095);
      inc_v_r     <= 1'b0;
      fl_v1_r     <= 1'b0;
      fl_v2_r     <= 1'b0;
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      front_r     <= front_nxt;
      inc_v_r     <= inc_v_nxt;
      fl_v1_r     <= fl_v1_nxt;
      fl_v2_r     <= fl_v1_r;
      fwd_v_r     <= fl_v2_r;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          rch_pkg::CFG_FIRST_BASE: first_r <= cfg_data;
          rch_pkg::CFG_LAST_BASE:  last_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    len_r      <= len_nxt;
    stop_r     <= stop_nxt;
    rend_r     <= rend_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    idx_r      <= idx_nxt;
    inc_addr_r <= inc_addr_nxt;
    fl_bin_r   <= fl_bin;
    fwd_bin_r  <= fl_bin_r;
    fwd_val_r  <= hb_wdata;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/rch_checker.sv
module rch_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rch_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // clearing pass follows reset: no transfer is taken right after it
  a_rst_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: an accepted transfer stalls the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

endmodule

bind region_coverage_histogram rch_checker u_rch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rch_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = CFG_FIRST_BASE;
  logic [POS_W-1:0]    cfg_data = '0;

  region_coverage_histogram dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block state
  logic [POS_W-1:0]          cov_first = '0;
  logic [POS_W-1:0]          cov_last = 31'd4095;
  logic [DEPTH_BITS_DEF-1:0] base_depth [MAX_REGION_DEF];
  int unsigned               depth_hist [HIST_BINS_DEF];
  longint unsigned           front = 0;

  out_item_t   pending_reports [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned n_adds = 0;
  int unsigned n_bins = 0;
  int unsigned n_checked = 0;
  int unsigned n_regions = 0;

  initial begin
    foreach (base_depth[i]) base_depth[i] = '0;
    foreach (depth_hist[i]) depth_hist[i] = 0;
  end

  function automatic out_item_t track_coverage(input in_item_t it);
    out_item_t       r;
    longint unsigned len, st, stop, lo, hi, fb, i;
    int unsigned     d;
    r = '0;
    fb = 64'(cov_first);
    if (cov_last < cov_first) len = 0;
    else len = longint'(cov_last) - longint'(cov_first) + 1;
    if (len > MAX_REGION_DEF) len = MAX_REGION_DEF;
    if (it.action == ACT_ADD) begin
      st = 64'(it.read_start);
      stop = st + 64'(it.read_span);
      if (len != 0 && ((st >= fb && st < fb + len) || (stop >= fb && stop < fb + len))) begin
        lo = (st > fb) ? st - fb : 0;
        hi = stop - fb;
        if (hi >= len) hi = len - 1;
        for (i = lo; i <= hi; i++) begin
          if (base_depth[i] != '1) base_depth[i]++;
        end
        if (lo > front) begin
          for (i = front; i < lo; i++) begin
            d = 32'(base_depth[i]);
            if (d > HIST_BINS_DEF - 1) d = HIST_BINS_DEF - 1;
            depth_hist[d]++;
          end
          front = lo;
        end
      end
    end else begin
      if (depth_hist[it.bin_select] > 32'(OUT_MAX)) r.bin_count = OUT_MAX;
      else r.bin_count = OUT_W'(depth_hist[it.bin_select]);
    end
    r.finalized_front = front[OUT_W-1:0];
    return r;
  endfunction

  // Receiver: random stall, transfers decided on the falling edge
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(negedge clk) begin : report_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual count %0d front %0d",
                 $time, out_data.bin_count, out_data.finalized_front);
      end else begin
        want = pending_reports.pop_front();
        n_checked++;
        if (out_data.bin_count !== want.bin_count) begin
          errors++;
          $display("%0t: bin_count expected %0d actual %0d",
                   $time, want.bin_count, out_data.bin_count);
        end
        if (out_data.finalized_front !== want.finalized_front) begin
          errors++;
          $display("%0t: finalized_front expected %0d actual %0d",
                   $time, want.finalized_front, out_data.finalized_front);
        end
      end
    end
  end

  task automatic send_item(input in_item_t it);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pending_reports.push_back(track_coverage(it));
    if (it.action == ACT_ADD) n_adds++;
    else n_bins++;
  endtask

  task automatic add_read(input logic [POS_W-1:0] start, input logic [SPAN_W-1:0] span);
    in_item_t it;
    it = '0;
    it.action = ACT_ADD;
    it.read_start = start;
    it.read_span = span;
    send_item(it);
  endtask

  task automatic read_bin(input logic [SEL_W-1:0] sel);
    in_item_t it;
    it = '0;
    it.action = ACT_BIN;
    it.bin_select = sel;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_region(input logic [POS_W-1:0] first_base,
                            input logic [POS_W-1:0] last_base);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_FIRST_BASE;
    cfg_data <= first_base;
    @(posedge clk);
    cfg_addr <= CFG_LAST_BASE;
    cfg_data <= last_base;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cov_first = first_base;
    cov_last = last_base;
    n_regions++;
  endtask

  // Default region straight after reset
  task automatic test_reset_and_reads();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    read_bin(0);
    read_bin(8'hFF);
    add_read(0, 0);
    add_read(6, 2);
    add_read(3, 1);       // starts behind the front
    add_read(5000, 100);  // beyond the region
    add_read(7, 16'hFFFF);
    read_bin(0);
    read_bin(1);
  endtask

  task automatic test_region_cases();
    send_idle_pct = 19;
    recv_stall_pct = 19;
    set_region(31'h7FFF_FF9C, 31'h7FFF_FFFF);
    add_read(31'h7FFF_FFFF, 16'hFFFF);
    add_read(31'h7FFF_FF38, 150);     // only the end lands inside
    add_read(0, 16'hFFFF);
    set_region(0, 0);
    add_read(0, 16'hFFFF);
    add_read(1, 0);
    set_region(10, 9);                // inverted, nothing counts
    add_read(10, 5);
    add_read(9, 1);
    read_bin(1);
    set_region(0, 31'h7FFF_FFFF);     // cut to the maximum region size
    add_read(4096, 0);
    add_read(50, 10);
    set_region(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    add_read(31'h7FFF_FFFF, 0);
    add_read(31'h7FFF_FFFE, 1);
    read_bin(8'hFF);
    set_region(0, 4095);
  endtask

  // Pile depth past the top bin, then flush it
  task automatic test_deep_depth();
    send_idle_pct = 19;
    recv_stall_pct = 19;
    repeat (300) add_read(200, 3);
    add_read(230, 0);
    read_bin(SEL_W'(HIST_BINS_DEF - 1));
    read_bin(254);
    read_bin(1);
    read_bin(0);
    wait_drained();
  endtask

  task automatic test_random_stream();
    in_item_t    it;
    int unsigned cursor, roll, back;
    cursor = 240;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          set_region(0, 4095);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          set_region(31'h7FFF_F000, 31'h7FFF_FFFF);
          send_idle_pct = 50;
          recv_stall_pct = 0;
        end
        2: begin
          set_region(31'd123456789, 31'd123460884);
          send_idle_pct = 0;
          recv_stall_pct = 50;
        end
        default: begin
          set_region(31'h4000_0000, 31'h7FFF_FFFF);
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
      endcase
      for (int k = 0; k < 275; k++) begin
        it.read_start = POS_W'($urandom());
        it.read_span = SPAN_W'($urandom());
        it.bin_select = SEL_W'($urandom());
        roll = $urandom_range(99);
        if (roll < 15) begin
          it.action = ACT_BIN;
        end else if (roll < 22) begin
          it.action = ACT_ADD;
        end else if (roll < 30) begin
          it.action = ACT_ADD;
          back = $urandom_range(60, 1);
          it.read_start = POS_W'(32'(cov_first) + ((cursor > back) ? cursor - back : 0));
          it.read_span = SPAN_W'($urandom_range(20));
        end else begin
          it.action = ACT_ADD;
          cursor += $urandom_range(6);
          if (cursor > 4095) cursor = 4095;
          it.read_start = POS_W'(32'(cov_first) + cursor);
          if ($urandom_range(39) != 0) it.read_span = SPAN_W'($urandom_range(40));
        end
        send_item(it);
        if (k % 100 == 99) wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_and_reads();
    test_region_cases();
    test_deep_depth();
    test_random_stream();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d alignments and %0d bin reads over %0d region settings;",
             n_adds, n_bins, n_regions);
    $display("checked %0d results, front reached %0d, %0d errors.",
             n_checked, front, errors);
    if (errors == 0) begin
      $display("PASS region_coverage_histogram");
    end else begin
      $display("FAIL region_coverage_histogram");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, pending_reports.size());
    $display("FAIL region_coverage_histogram");
    $finish;
  end

endmodule
